[src/sha1md_pkg.sv]
// Shared types and constants for the SHA-1 digest block.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package sha1md_pkg;

  localparam int CNT_W = 61;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K_R0 = 32'h5a827999;
  localparam logic [31:0] K_R1 = 32'h6ed9eba1;
  localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_R3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] PHASE1     = 7'd20;
  localparam logic [6:0] PHASE2     = 7'd40;
  localparam logic [6:0] PHASE3     = 7'd60;
  localparam logic [2:0] LAST_WORD  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic put_byte;
    logic step;
    logic load_vars;
    logic fold;
    logic reinit;
  } ctl_t;

endpackage

`default_nettype wire

[src/sha1md_in_if.sv]
// Message byte channel: valid/ready handshake with the byte payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source(output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink(input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

`default_nettype wire

[src/sha1md_out_if.sv]
// Digest word channel: valid/ready handshake with one digest word per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        last_word;

  modport source(output valid, digest_word, word_number, last_word, input ready);
  modport sink(input valid, digest_word, word_number, last_word, output ready);
endinterface

`default_nettype wire

[src/sha1md_sched.sv]
// Block buffer and message schedule: packs bytes into a 512-bit shift line
// and rolls the 16-word schedule window one word per round. Uses sha1md_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha1md_sched
  import sha1md_pkg::*;
(
  input  wire logic        clk,
  input  wire ctl_t        ctl,
  input  wire logic [7:0]  byte_val,
  output      logic [31:0] w_cur
);

  logic [15:0][31:0] win_r;
  logic [15:0][31:0] win_nxt;
  logic [511:0]      flat;
  logic [31:0]       mix;

  assign flat  = win_r;
  assign w_cur = win_r[15];
  assign mix   = win_r[2] ^ win_r[7] ^ win_r[13] ^ win_r[15];

  always_comb begin
    win_nxt = win_r;
    if (ctl.put_byte) begin
      win_nxt = {flat[503:0], byte_val};
    end else if (ctl.step) begin
      win_nxt = {win_r[14:0], mix[30:0], mix[31]};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

`default_nettype wire

[src/sha1md_round.sv]
// Shared round unit: working variables a..e, one SHA-1 round per cycle,
// and the five chaining words. Uses sha1md_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha1md_round
  import sha1md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctl_t        ctl,
  input  wire logic [6:0]  rnd,
  input  wire logic [31:0] w_cur,
  input  wire logic [2:0]  word_idx,
  output      logic [31:0] digest
);

  logic [31:0] chain_r [5];
  logic [31:0] chain_nxt [5];
  logic [31:0] vars_r [5];
  logic [31:0] vars_nxt [5];
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] a_rot;
  logic [31:0] tmp;

  always_comb begin
    if (rnd < PHASE1) begin
      f = (vars_r[1] & vars_r[2]) | (~vars_r[1] & vars_r[3]);
      k = K_R0;
    end else if (rnd < PHASE2) begin
      f = vars_r[1] ^ vars_r[2] ^ vars_r[3];
      k = K_R1;
    end else if (rnd < PHASE3) begin
      f = (vars_r[1] & vars_r[2]) | (vars_r[1] & vars_r[3]) | (vars_r[2] & vars_r[3]);
      k = K_R2;
    end else begin
      f = vars_r[1] ^ vars_r[2] ^ vars_r[3];
      k = K_R3;
    end
  end

  assign a_rot = {vars_r[0][26:0], vars_r[0][31:27]};
  assign tmp   = a_rot + f + vars_r[4] + k + w_cur;

  always_comb begin
    vars_nxt  = vars_r;
    chain_nxt = chain_r;
    if (ctl.load_vars) begin
      vars_nxt = chain_r;
    end else if (ctl.step) begin
      vars_nxt[0] = tmp;
      vars_nxt[1] = vars_r[0];
      vars_nxt[2] = {vars_r[1][1:0], vars_r[1][31:2]};
      vars_nxt[3] = vars_r[2];
      vars_nxt[4] = vars_r[3];
    end
    if (ctl.fold) begin
      for (int i = 0; i < 5; i++) begin
        chain_nxt[i] = chain_r[i] + vars_r[i];
      end
    end else if (ctl.reinit) begin
      chain_nxt = H_INIT;
    end
  end

  always_comb begin
    case (word_idx)
      3'd0:    digest = chain_r[0];
      3'd1:    digest = chain_r[1];
      3'd2:    digest = chain_r[2];
      3'd3:    digest = chain_r[3];
      3'd4:    digest = chain_r[4];
      default: digest = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    vars_r <= vars_nxt;
    if (!rst_n) begin
      chain_r <= H_INIT;
    end else begin
      chain_r <= chain_nxt;
    end
  end

endmodule

`default_nettype wire

[src/sha1md_ctrl.sv]
// Sequencer: byte position and message length, padding bytes, round
// counting and digest readout. Uses sha1md_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha1md_ctrl
  import sha1md_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_data,
  input  wire logic       in_present,
  input  wire logic       in_end,
  output      logic       in_ready,
  input  wire logic       out_ready,
  output      logic       out_valid,
  output      logic [2:0] word_idx,
  output      logic [7:0] byte_val,
  output      logic [6:0] rnd,
  output      ctl_t       ctl
);

  state_t           state_r, state_nxt;
  state_t           ret_r, ret_nxt;
  logic [5:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [6:0]       rnd_r, rnd_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic             first_r, first_nxt;
  logic             lenph_r, lenph_nxt;
  logic [63:0]      bit_len;
  logic [7:0]       len_byte;
  logic             len_act;

  assign bit_len  = {cnt_r, 3'b000};
  assign len_byte = bit_len[{~pos_r[2:0], 3'b000} +: 8];
  assign len_act  = !first_r && (pos_r == LEN_POS || lenph_r);
  assign word_idx = idx_r;
  assign rnd      = rnd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      pos_r   <= '0;
      cnt_r   <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      first_r <= 1'b0;
      lenph_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      first_r <= first_nxt;
      lenph_r <= lenph_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    first_nxt = first_r;
    lenph_nxt = lenph_r;
    ctl       = '0;
    byte_val  = in_data;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_present) begin
            ctl.put_byte = 1'b1;
            pos_nxt      = pos_r + 6'd1;
            cnt_nxt      = cnt_r + 1'b1;
          end
          if (in_present && pos_r == BLOCK_LAST) begin
            ctl.load_vars = 1'b1;
            rnd_nxt       = '0;
            state_nxt     = ST_ROUND;
            ret_nxt       = in_end ? ST_PAD : ST_IDLE;
            first_nxt     = 1'b1;
          end else if (in_end) begin
            state_nxt = ST_PAD;
            first_nxt = 1'b1;
          end
        end
      end
      ST_PAD: begin
        ctl.put_byte = 1'b1;
        if (first_r) begin
          byte_val = PAD_BYTE;
        end else if (len_act) begin
          byte_val = len_byte;
        end else begin
          byte_val = 8'h00;
        end
        pos_nxt   = pos_r + 6'd1;
        first_nxt = 1'b0;
        lenph_nxt = len_act;
        if (pos_r == BLOCK_LAST) begin
          ctl.load_vars = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = ST_ROUND;
          ret_nxt       = len_act ? ST_OUT : ST_PAD;
          lenph_nxt     = 1'b0;
        end
      end
      ST_ROUND: begin
        ctl.step = 1'b1;
        rnd_nxt  = rnd_r + 7'd1;
        if (rnd_r == ROUND_LAST) begin
          rnd_nxt   = '0;
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        ctl.fold  = 1'b1;
        idx_nxt   = '0;
        state_nxt = ret_r;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_WORD) begin
            idx_nxt    = '0;
            ctl.reinit = 1'b1;
            cnt_nxt    = '0;
            pos_nxt    = '0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/sha1_message_digest_unit.sv]
// SHA-1 digest over a byte stream: sequencer, schedule buffer and round unit.
// Depends on sha1md_pkg, sha1md_in_if, sha1md_out_if, sha1md_sched,
// sha1md_round and sha1md_ctrl.
//
// Usage: the in_ch channel takes one beat per message byte (byte_present
// high). A beat with end_of_message high closes the message; it may carry a
// byte or none (empty end beat). The out_ch channel then gives five beats,
// digest words h0..h4 with word_number 0..4, last_word high on the fifth.
// The 64th byte of a block starts the compression: 80 rounds on the single
// round unit, one round per cycle, then a fold of the result into the
// chaining words; in_ch is held off until the fold is done. An end beat
// then feeds 0x80, zero fill and the 8-byte length one byte per cycle,
// with one or two compressions in between; in_ch takes no beat meanwhile.
// While digest words are pending, in_ch is not ready; a stall on out_ch
// holds the current word. After the fifth word the chaining words return
// to the initial values and the byte count to zero.
// Reset: synchronous, active low; clears the sequencer, the byte count and
// loads the initial chaining words.
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_digest_unit
  import sha1md_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  sha1md_in_if.sink   in_ch,
  sha1md_out_if.source out_ch
);

  ctl_t        ctl;
  logic [7:0]  byte_val;
  logic [6:0]  rnd_w;
  logic [2:0]  word_idx;
  logic [31:0] w_cur;
  logic [31:0] digest;

  sha1md_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_data    (in_ch.data_byte),
    .in_present (in_ch.byte_present),
    .in_end     (in_ch.end_of_message),
    .in_ready   (in_ch.ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .word_idx   (word_idx),
    .byte_val   (byte_val),
    .rnd        (rnd_w),
    .ctl        (ctl)
  );

  sha1md_sched u_sched (
    .clk      (clk),
    .ctl      (ctl),
    .byte_val (byte_val),
    .w_cur    (w_cur)
  );

  sha1md_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rnd      (rnd_w),
    .w_cur    (w_cur),
    .word_idx (word_idx),
    .digest   (digest)
  );

  assign out_ch.digest_word = digest;
  assign out_ch.word_number = word_idx;
  assign out_ch.last_word   = (word_idx == LAST_WORD);

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_w <= ROUND_LAST)
    else $error("round counter out of range");

  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while digest pending");

  a_last_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_word |-> out_ch.word_number == LAST_WORD)
    else $error("last word flag on wrong word");

  a_resume: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last_word |=> in_ch.ready && !out_ch.valid)
    else $error("no return to idle after last digest word");

endmodule

`default_nettype wire

[tb/tb_sha1_message_digest_unit.sv]
// Testbench for sha1_message_digest_unit: byte beats in, five digest word beats out.
// Depends on sha1md_pkg, sha1md_in_if, sha1md_out_if and sha1_message_digest_unit; a class-based tracker
// recomputes each digest and checks every word beat against it.
`timescale 1ns / 1ps

module tb_sha1_message_digest_unit;
  import sha1md_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned BEAT_TARGET    = 370;
  localparam int unsigned CALM_FROM      = 300;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  number;
    logic        last;
  } digest_beat_t;

  class digest_tracker;
    logic [31:0]      chain [5];
    logic [7:0]       block_bytes [64];
    logic [CNT_W-1:0] byte_count;
    digest_beat_t     awaited_words [$];
    int unsigned      failures;

    function new();
      failures = 0;
      restart();
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = H_INIT[i];
      byte_count = '0;
    endfunction

    function void compress_block();
      logic [31:0] sched [80];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      for (int i = 0; i < 16; i++)
        sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 80; i++) begin
        x = sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16];
        sched[i] = {x[30:0], x[31]};
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int r = 0; r < 80; r++) begin
        if (r < PHASE1) begin
          f = (b & c) | (~b & d); k = K_R0;
        end else if (r < PHASE2) begin
          f = b ^ c ^ d; k = K_R1;
        end else if (r < PHASE3) begin
          f = (b & c) | (b & d) | (c & d); k = K_R2;
        end else begin
          f = b ^ c ^ d; k = K_R3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + sched[r];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    function void place(int unsigned pos, logic [7:0] v);
      block_bytes[pos] = v;
      if (pos == BLOCK_LAST) compress_block();
    endfunction

    function void note_item(logic [7:0] data, logic present, logic last);
      logic [63:0] bit_len;
      int unsigned pos;
      digest_beat_t beat;
      if (present) begin
        place(int'(byte_count[5:0]), data);
        byte_count = byte_count + 1'b1;
      end
      if (!last) return;
      bit_len = {byte_count, 3'b000};
      pos = int'(byte_count[5:0]);
      place(pos, PAD_BYTE);
      pos = (pos + 1) % 64;
      while (pos != LEN_POS) begin
        place(pos, 8'h00);
        pos = (pos + 1) % 64;
      end
      for (int i = 0; i < 8; i++) place(int'(LEN_POS) + i, bit_len[63 - 8*i -: 8]);
      for (int j = 0; j < 5; j++) begin
        beat.word   = chain[j];
        beat.number = 3'(j);
        beat.last   = (3'(j) == LAST_WORD);
        awaited_words.insert(awaited_words.size(), beat);
      end
      restart();
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] number, logic last);
      digest_beat_t exp;
      if (awaited_words.size() == 0) begin
        $error("digest_word: expected none, got %h", word);
        failures++;
        return;
      end
      exp = awaited_words.pop_front();
      if (word !== exp.word) begin
        $error("digest_word: expected %h, got %h", exp.word, word);
        failures++;
      end
      if (number !== exp.number) begin
        $error("word_number: expected %0d, got %0d", exp.number, number);
        failures++;
      end
      if (last !== exp.last) begin
        $error("last_word: expected %0d, got %0d", exp.last, last);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sha1md_in_if  in_ch();
  sha1md_out_if out_ch();

  sha1_message_digest_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  digest_tracker tracker;
  bit            calm_tail     = 1'b0;
  int unsigned   in_gap_pct    = 0;
  int unsigned   out_stall_pct = 0;
  int unsigned   beats_sent    = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic send_beat(input logic [7:0] b, input logic present, input logic last);
    if (!calm_tail && $urandom_range(0, 99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.byte_present   <= present;
    in_ch.end_of_message <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_item(b, present, last);
    beats_sent++;
  endtask

  task automatic send_message(input int unsigned n_bytes, input bit close_with_byte);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 11) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b1, close_with_byte && (i == n_bytes - 1));
    end
    if (!close_with_byte || n_bytes == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic pick_pacing();
    case ($urandom_range(0, 2))
      0: in_gap_pct = 0;
      1: in_gap_pct = 20;
      default: in_gap_pct = 60;
    endcase
    case ($urandom_range(0, 2))
      0: out_stall_pct = 0;
      1: out_stall_pct = 20;
      default: out_stall_pct = 60;
    endcase
  endtask

  initial begin : digest_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        tracker.check_word(out_ch.digest_word, out_ch.word_number, out_ch.last_word);
      if (stall_left != 0 && !calm_tail) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 99) < out_stall_pct) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $error("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int unsigned n_bytes;
    int unsigned pick;
    tracker = new();
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.data_byte      <= 8'h00;
    in_ch.byte_present   <= 1'b0;
    in_ch.end_of_message <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, ignored beat, single-byte extremes, "abc", 80 7f 01, empty again
    in_gap_pct    = 30;
    out_stall_pct = 30;
    send_beat(8'h5a, 1'b0, 1'b1);
    send_beat(8'hc3, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h63, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'h7f, 1'b1, 1'b0);
    send_beat(8'h01, 1'b1, 1'b1);
    send_beat(8'hff, 1'b0, 1'b1);

    while (beats_sent < BEAT_TARGET) begin
      if (beats_sent >= CALM_FROM) calm_tail = 1'b1;
      pick_pacing();
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        n_bytes = $urandom_range(0, 20);
      end else if (pick == 6) begin
        n_bytes = $urandom_range(50, 70);
      end else if (pick == 7) begin
        case ($urandom_range(0, 3))
          0: n_bytes = 55;
          1: n_bytes = 56;
          2: n_bytes = 63;
          default: n_bytes = 64;
        endcase
      end else if (pick == 8) begin
        n_bytes = $urandom_range(118, 130);
      end else begin
        n_bytes = $urandom_range(0, 3);
      end
      if (n_bytes > BEAT_TARGET - beats_sent) n_bytes = BEAT_TARGET - beats_sent;
      send_message(n_bytes, $urandom_range(0, 1));
    end
    in_ch.valid <= 1'b0;

    while (tracker.awaited_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
src/sha1md_pkg.sv
src/sha1md_in_if.sv
src/sha1md_out_if.sv
src/sha1md_sched.sv
src/sha1md_round.sv
src/sha1md_ctrl.sv
src/sha1_message_digest_unit.sv
tb/tb_sha1_message_digest_unit.sv
